// ===== rtl/assert_macros.svh =====
// Assertion helpers for the block's port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bgbs_pkg.sv =====
package bgbs_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int MAX_WINDOW  = 32;
   localparam int SLOT_W      = $clog2(MAX_WINDOW);
   localparam int HEIGHT_MAX  = 2048;
   localparam int DIM_W       = 12;
   localparam int WIN_W       = 6;
   localparam int CNT_W       = 11;
   localparam int TOTAL_W     = 32;
   localparam int MEAN_W      = 27;
   localparam int FRAC_BITS   = 16;
   localparam int NUMER_W     = TOTAL_W + FRAC_BITS + 1;
   localparam int DENOM_W     = 23;
   localparam int MEM_W       = MAX_WINDOW + CNT_W;

   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_WINDOW_SIZE = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_CALC,
      ST_MUL,
      ST_DSTART,
      ST_DIV,
      ST_LOAD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic mod_step;
      logic mem_read;
      logic update;
      logic mul;
      logic div_start;
      logic mean_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic mod_last;
      logic mean_needed;
      logic div_done;
   } status_type;

endpackage

// ===== rtl/bgbs_mean_div.sv =====
module bgbs_mean_div
   import bgbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUMER_W-1:0]   numer,
   input  logic [DENOM_W-1:0]   denom,
   output logic                 done,
   output logic [MEAN_W-1:0]    quot
);

   localparam int STEP_W = $clog2(NUMER_W);

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NUMER_W-1:0]  num_ff, num_in;
   logic [DENOM_W-1:0]  den_ff, den_in;
   logic [DENOM_W-1:0]  rem_ff, rem_in;
   logic [MEAN_W-1:0]   quot_ff, quot_in;
   logic [DENOM_W:0]    trial;
   logic                take;

   always_comb begin
      trial   = {rem_ff, num_ff[NUMER_W-1]};
      take    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      step_in = step_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      done    = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         rem_in  = take ? DENOM_W'(trial - {1'b0, den_ff}) : trial[DENOM_W-1:0];
         quot_in = {quot_ff[MEAN_W-2:0], take};
         num_in  = {num_ff[NUMER_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUMER_W - 1)) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// ===== rtl/bgbs_datapath.sv =====
module bgbs_datapath
   import bgbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  logic                 req_cell_occupied,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_window_valid,
   output logic [CNT_W-1:0]     rsp_window_count,
   output logic [TOTAL_W-1:0]   rsp_total_count,
   output logic                 rsp_frame_end,
   output logic [MEAN_W-1:0]    rsp_mean_count,
   output logic                 rsp_no_windows
);

   localparam int MOD_STEPS = ADDR_W;
   localparam int MSTEP_W   = $clog2(MOD_STEPS);

   logic [DIM_W-1:0]   height_ff, width_ff;
   logic [WIN_W-1:0]   win_ff;

   logic [ADDR_W-1:0]  clr_addr_ff;
   logic               cell_ff;
   logic [ADDR_W-1:0]  row_ff, col_ff;
   logic [ADDR_W-1:0]  rdiv_ff, cdiv_ff;
   logic [WIN_W-1:0]   rrem_ff, crem_ff;
   logic [MSTEP_W-1:0] mstep_ff;
   logic [MEM_W-1:0]   rd_ff;
   logic [CNT_W-1:0]   wsum_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [CNT_W-1:0]   recent_ff [MAX_WINDOW];
   logic [DENOM_W-1:0] n_ff;

   logic               win_valid_ff;
   logic [CNT_W-1:0]   win_count_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               fend_ff;
   logic               none_ff;
   logic [MEAN_W-1:0]  mean_ff;

   logic [MEM_W-1:0]   hist_mem [MAX_WIDTH];

   // effective dimensions and flags
   logic [DIM_W-1:0]   h_eff, w_eff;
   logic               s_ok, last_col, last_row, none_now, valid_now;
   logic [DIM_W-1:0]   s_ext, r_ext, c_ext;
   logic [SLOT_W-1:0]  rslot, cslot;
   logic               old_bit;
   logic [CNT_W-1:0]   cs, old_cs, wsum_in;
   logic [MAX_WINDOW-1:0] hist_new;
   logic [TOTAL_W-1:0] total_in;
   logic [DIM_W-1:0]   na, nb;
   logic [NUMER_W-1:0] numer;
   logic               div_done;
   logic [MEAN_W-1:0]  div_quot;
   logic [WIN_W:0]     rtrial, ctrial;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [MEM_W-1:0]   mem_wdata;

   always_comb begin
      if (height_ff == '0)
         h_eff = DIM_W'(1);
      else if (height_ff > DIM_W'(HEIGHT_MAX))
         h_eff = DIM_W'(HEIGHT_MAX);
      else
         h_eff = height_ff;
      if (width_ff == '0)
         w_eff = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_WIDTH))
         w_eff = DIM_W'(MAX_WIDTH);
      else
         w_eff = width_ff;
   end

   assign s_ext     = DIM_W'(win_ff);
   assign r_ext     = DIM_W'(row_ff);
   assign c_ext     = DIM_W'(col_ff);
   assign s_ok      = (win_ff != '0) && (win_ff <= WIN_W'(MAX_WINDOW));
   assign last_col  = c_ext >= w_eff - 1'b1;
   assign last_row  = r_ext >= h_eff - 1'b1;
   assign none_now  = !s_ok || (s_ext > h_eff) || (s_ext > w_eff);
   assign valid_now = s_ok && (r_ext + 1'b1 >= s_ext) && (c_ext + 1'b1 >= s_ext);
   assign rslot     = rrem_ff[SLOT_W-1:0];
   assign cslot     = crem_ff[SLOT_W-1:0];

   // remainder steps for row % window and column % window
   assign rtrial = {rrem_ff, rdiv_ff[ADDR_W-1]};
   assign ctrial = {crem_ff, cdiv_ff[ADDR_W-1]};

   always_comb begin
      old_bit  = (r_ext >= s_ext) ? rd_ff[CNT_W + rslot] : 1'b0;
      cs       = (row_ff == '0) ? CNT_W'(cell_ff)
                 : rd_ff[CNT_W-1:0] + CNT_W'(cell_ff) - CNT_W'(old_bit);
      hist_new = rd_ff[MEM_W-1:CNT_W];
      hist_new[rslot] = cell_ff;
      old_cs   = (c_ext >= s_ext) ? recent_ff[cslot] : '0;
      wsum_in  = ((col_ff == '0) ? CNT_W'(0) : wsum_ff) + cs - old_cs;
      total_in = total_ff + (valid_now ? TOTAL_W'(wsum_in) : TOTAL_W'(0));
      na       = w_eff - s_ext + 1'b1;
      nb       = h_eff - s_ext + 1'b1;
      numer    = {1'b0, rsp_total_ff, FRAC_BITS'(0)} + NUMER_W'(n_ff >> 1);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = col_ff;
      mem_wdata = {hist_new, cs};
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (cmd.update && s_ok) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         hist_mem[mem_waddr] <= mem_wdata;
      if (cmd.mem_read)
         rd_ff <= hist_mem[col_ff];
   end

   bgbs_mean_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (numer),
      .denom (n_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff   <= DIM_W'(8);
         width_ff    <= DIM_W'(8);
         win_ff      <= WIN_W'(2);
         clr_addr_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         wsum_ff     <= '0;
         total_ff    <= '0;
         mstep_ff    <= '0;
         for (int i = 0; i < MAX_WINDOW; i++)
            recent_ff[i] <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_GRID_HEIGHT: height_ff <= csr_wdata;
               CSR_GRID_WIDTH:  width_ff  <= csr_wdata;
               CSR_WINDOW_SIZE: win_ff    <= csr_wdata[WIN_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clear_step)
            clr_addr_ff <= clr_addr_ff + 1'b1;
         if (cmd.load)
            mstep_ff <= '0;
         else if (cmd.mod_step)
            mstep_ff <= mstep_ff + 1'b1;
         if (cmd.update) begin
            if (s_ok) begin
               recent_ff[cslot] <= cs;
               wsum_ff          <= wsum_in;
            end
            // drop the total after the frame's last cell
            total_ff <= (last_col && last_row) ? TOTAL_W'(0) : total_in;
            // advance raster position
            if (last_col) begin
               col_ff <= '0;
               if (last_row) begin
                  row_ff <= '0;
               end else begin
                  row_ff <= row_ff + 1'b1;
               end
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cell_ff <= req_cell_occupied;
         rdiv_ff <= row_ff;
         cdiv_ff <= col_ff;
         rrem_ff <= '0;
         crem_ff <= '0;
      end else if (cmd.mod_step) begin
         rdiv_ff <= {rdiv_ff[ADDR_W-2:0], 1'b0};
         cdiv_ff <= {cdiv_ff[ADDR_W-2:0], 1'b0};
         rrem_ff <= (rtrial >= {1'b0, win_ff}) ? WIN_W'(rtrial - {1'b0, win_ff})
                                               : rtrial[WIN_W-1:0];
         crem_ff <= (ctrial >= {1'b0, win_ff}) ? WIN_W'(ctrial - {1'b0, win_ff})
                                               : ctrial[WIN_W-1:0];
      end
      if (cmd.update) begin
         win_valid_ff <= valid_now;
         win_count_ff <= valid_now ? wsum_in : CNT_W'(0);
         rsp_total_ff <= total_in;
         fend_ff      <= last_col && last_row;
         none_ff      <= last_col && last_row && none_now;
         mean_ff      <= '0;
      end
      if (cmd.mul)
         n_ff <= DENOM_W'(na) * DENOM_W'(nb);
      if (cmd.mean_load)
         mean_ff <= div_quot;
   end

   assign status.clear_last  = (clr_addr_ff == ADDR_W'(MAX_WIDTH - 1));
   assign status.mod_last    = (mstep_ff == MSTEP_W'(MOD_STEPS - 1));
   assign status.mean_needed = fend_ff && !none_ff;
   assign status.div_done    = div_done;

   assign rsp_window_valid = win_valid_ff;
   assign rsp_window_count = win_count_ff;
   assign rsp_total_count  = rsp_total_ff;
   assign rsp_frame_end    = fend_ff;
   assign rsp_mean_count   = mean_ff;
   assign rsp_no_windows   = none_ff;

endmodule

// ===== rtl/bgbs_ctrl.sv =====
module bgbs_ctrl
   import bgbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  status_type  status,
   output cmd_type     cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_CLEAR;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last)
               state_in = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_CALC;
         end
         ST_CALC: begin
            cmd.update = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            if (status.mean_needed) begin
               cmd.mul  = 1'b1;
               state_in = ST_DSTART;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done)
               state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.mean_load = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/binary_grid_box_sum_average.sv =====
// Box-window counter over a binary grid streamed one cell per beat in raster order.
// Each accepted cell gives one result beat with the count of the square window ending
// there, the running frame total and, on the last cell, the mean count per window
// (16 fractional bits, rounded half up). After a cell is accepted the block finds its
// row and column remainders by the window size, reads the history RAM, makes one update
// and decides on the mean, and then offers the result beat; the next cell is taken in the
// cycle after that beat is taken. On the frame's last cell the mean adds the divider
// start, its 49 steps and the mean load. One cell is in flight at a time. After reset a
// pass clears the row history RAM before the first cell is taken; configuration writes
// are taken during it.
module binary_grid_box_sum_average
   import bgbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cell_occupied,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_window_valid,
   output logic [CNT_W-1:0]     rsp_window_count,
   output logic [TOTAL_W-1:0]   rsp_total_count,
   output logic                 rsp_frame_end,
   output logic [MEAN_W-1:0]    rsp_mean_count,
   output logic                 rsp_no_windows
);

   cmd_type    cmd;
   status_type status;

   bgbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bgbs_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_cell_occupied (req_cell_occupied),
      .cmd               (cmd),
      .status            (status),
      .rsp_window_valid  (rsp_window_valid),
      .rsp_window_count  (rsp_window_count),
      .rsp_total_count   (rsp_total_count),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_mean_count    (rsp_mean_count),
      .rsp_no_windows    (rsp_no_windows)
   );

endmodule

// ===== rtl/bgbs_checker.sv =====
`include "assert_macros.svh"

module bgbs_checker
   import bgbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_ready,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_window_valid,
   input  logic [CNT_W-1:0]     rsp_window_count,
   input  logic [TOTAL_W-1:0]   rsp_total_count,
   input  logic                 rsp_frame_end,
   input  logic [MEAN_W-1:0]    rsp_mean_count,
   input  logic                 rsp_no_windows
);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_total_count), "rsp beat changed while stalled")
   `CHK_SAME(a_one_in_flight, clock, reset, req_ready, !rsp_valid, "input taken while a result waits")
   `CHK_SAME(a_mean_only_at_end, clock, reset, rsp_valid && (!rsp_frame_end || rsp_no_windows), rsp_mean_count == '0, "mean outside a frame end with windows")
   `CHK_SAME(a_none_at_end, clock, reset, rsp_valid && rsp_no_windows, rsp_frame_end && !rsp_window_valid, "no_windows off frame end or with a window")
   `CHK_SAME(a_count_zero, clock, reset, rsp_valid && !rsp_window_valid, rsp_window_count == '0, "count without a window")

endmodule

bind binary_grid_box_sum_average bgbs_checker u_chk (.*);
